// ===== rtl/gaps_pkg.sv =====
`timescale 1ns / 1ps
package gaps_pkg;

  // Grid and heap geometry.
  localparam int GRID_SIDE  = 32;
  localparam int HEAP_DEPTH = 1024;
  localparam int CELLS      = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int XY_W       = $clog2(GRID_SIDE);
  localparam int POS_W      = $clog2(HEAP_DEPTH + 1);
  localparam int STEP_W     = 8;
  localparam int G_W        = $clog2(CELLS * 255);
  localparam int F_W        = G_W + 1;

  // Fixed field widths of the ports.
  localparam int CFG_XY_W   = 5;
  localparam int LIMIT_W    = 11;
  localparam int CNT_W      = 11;
  localparam int OP_W       = 2;
  localparam int REQ_W      = 10;
  localparam int STAT_W     = 2;
  localparam int PCELL_W    = 10;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [OP_W-1:0] OP_FENCE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_REACHED = 2'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOPATH  = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_DEST_X  = 3'd2;
  localparam logic [2:0] REG_DEST_Y  = 3'd3;
  localparam logic [2:0] REG_STEP    = 3'd4;
  localparam logic [2:0] REG_LIMIT   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] cell_req;
    logic             fence;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   path_length;
    logic [PCELL_W-1:0] path_cell;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [CFG_XY_W-1:0] start_x;
    logic [CFG_XY_W-1:0] start_y;
    logic [CFG_XY_W-1:0] dest_x;
    logic [CFG_XY_W-1:0] dest_y;
    logic [STEP_W-1:0]   score_step;
    logic [LIMIT_W-1:0]  expansion_limit;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0] node;
    logic [G_W-1:0]    g;
    logic [F_W-1:0]    f;
  } heap_t;

  typedef enum logic [4:0] {
    S_RST, S_IDLE, S_DEC, S_RD, S_CLR, S_INIT, S_CHECK, S_NB, S_NBW, S_CMP,
    S_SU, S_SUW, S_NEXT, S_AFTER, S_POP1, S_POP2, S_PD, S_PD1, S_PD2, S_PD3,
    S_CLOSE, S_PATH0, S_PATH1, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    U_RST, U_IDLE, U_DEC, U_RD, U_CLR, U_INIT, U_CHECK, U_NB, U_NBW, U_CMP,
    U_SU, U_SUW, U_NEXT, U_AFTER, U_POP1, U_POP2, U_PD, U_PD1, U_PD2, U_PD3,
    U_CLOSE, U_PATH0, U_PATH1, U_FIN
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic accept;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic clr_last;
    logic at_dest;
    logic nb_ok;
    logic k_last;
    logic nb_skip;
    logic nb_open;
    logic heap_room;
    logic worse;
    logic pos_up;
    logic su_move;
    logic heap_empty;
    logic pop_last;
    logic c_in;
    logic c_sib;
    logic tail_stop;
    logic over_limit;
    logic cur_start;
    logic walk_more;
    logic rd_avail;
    logic out_free;
  } st_t;

  function automatic logic [XY_W-1:0] clamp_xy(input logic [CFG_XY_W-1:0] v);
    logic [XY_W-1:0] r;
    if (int'(v) >= GRID_SIDE) r = XY_W'(GRID_SIDE - 1);
    else r = XY_W'(v);
    return r;
  endfunction

  function automatic logic [1:0] opposite_dir(input logic [1:0] d);
    logic [1:0] r;
    case (d)
      DIR_LEFT:  r = DIR_RIGHT;
      DIR_UP:    r = DIR_DOWN;
      DIR_RIGHT: r = DIR_LEFT;
      default:   r = DIR_UP;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gaps_ram.sv =====
`timescale 1ns / 1ps
module gaps_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gaps_ctrl.sv =====
`timescale 1ns / 1ps
module gaps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  gaps_pkg::st_t  st,
  output gaps_pkg::cmd_t cmd
);
  import gaps_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_RST:   if (st.clr_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_DEC;
      S_DEC: begin
        case (st.op)
          OP_SEARCH: state_next = S_CLR;
          OP_READ:   state_next = st.rd_avail ? S_RD : S_FIN;
          default:   state_next = S_FIN;
        endcase
      end
      S_RD:    state_next = S_FIN;
      S_CLR:   if (st.clr_last) state_next = S_INIT;
      S_INIT:  state_next = S_CHECK;
      S_CHECK: state_next = st.at_dest ? S_PATH0 : S_NB;
      S_NB:    state_next = st.nb_ok ? S_NBW : S_NEXT;
      S_NBW: begin
        if (st.nb_skip) state_next = S_NEXT;
        else if (st.nb_open) state_next = S_CMP;
        else if (st.heap_room) state_next = S_SU;
        else state_next = S_NEXT;
      end
      S_CMP:   state_next = st.worse ? S_SU : S_NEXT;
      S_SU:    state_next = st.pos_up ? S_SUW : S_NEXT;
      S_SUW:   state_next = st.su_move ? S_SU : S_NEXT;
      S_NEXT:  state_next = st.k_last ? S_AFTER : S_NB;
      S_AFTER: state_next = st.heap_empty ? S_FIN : S_POP1;
      S_POP1:  state_next = S_POP2;
      S_POP2:  state_next = st.pop_last ? S_CLOSE : S_PD;
      S_PD:    state_next = st.c_in ? S_PD1 : S_CLOSE;
      S_PD1:   state_next = st.c_sib ? S_PD2 : S_PD3;
      S_PD2:   state_next = S_PD3;
      S_PD3:   state_next = st.tail_stop ? S_CLOSE : S_PD;
      S_CLOSE: state_next = st.over_limit ? S_PATH0 : S_CHECK;
      S_PATH0: state_next = st.cur_start ? S_FIN : S_PATH1;
      S_PATH1: state_next = st.walk_more ? S_PATH1 : S_FIN;
      S_FIN:   if (st.out_free) state_next = S_IDLE;
      default: state_next = S_RST;
    endcase
  end

  always_comb begin
    cmd.in_ready = (state == S_IDLE);
    cmd.accept   = (state == S_IDLE) && in_valid;
    case (state)
      S_RST:   cmd.uop = U_RST;
      S_IDLE:  cmd.uop = U_IDLE;
      S_DEC:   cmd.uop = U_DEC;
      S_RD:    cmd.uop = U_RD;
      S_CLR:   cmd.uop = U_CLR;
      S_INIT:  cmd.uop = U_INIT;
      S_CHECK: cmd.uop = U_CHECK;
      S_NB:    cmd.uop = U_NB;
      S_NBW:   cmd.uop = U_NBW;
      S_CMP:   cmd.uop = U_CMP;
      S_SU:    cmd.uop = U_SU;
      S_SUW:   cmd.uop = U_SUW;
      S_NEXT:  cmd.uop = U_NEXT;
      S_AFTER: cmd.uop = U_AFTER;
      S_POP1:  cmd.uop = U_POP1;
      S_POP2:  cmd.uop = U_POP2;
      S_PD:    cmd.uop = U_PD;
      S_PD1:   cmd.uop = U_PD1;
      S_PD2:   cmd.uop = U_PD2;
      S_PD3:   cmd.uop = U_PD3;
      S_CLOSE: cmd.uop = U_CLOSE;
      S_PATH0: cmd.uop = U_PATH0;
      S_PATH1: cmd.uop = U_PATH1;
      S_FIN:   cmd.uop = U_FIN;
      default: cmd.uop = U_IDLE;
    endcase
  end

endmodule

// ===== rtl/gaps_dp.sv =====
`timescale 1ns / 1ps
module gaps_dp (
  input  logic           clk,
  input  logic           rst,
  input  gaps_pkg::cmd_t cmd,
  input  gaps_pkg::cfg_t cfg,
  input  gaps_pkg::in_t  in_data,
  input  logic           out_ready,
  output gaps_pkg::st_t  st,
  output logic           out_valid,
  output gaps_pkg::out_t out_data
);
  import gaps_pkg::*;

  in_t               in_q;
  logic [CELL_W-1:0] cur, nb_cell, walk, clr;
  logic [G_W-1:0]    cur_g, it_g;
  logic [F_W-1:0]    it_f;
  logic [POS_W-1:0]  hc, pos, p;
  logic [POS_W:0]    c;
  logic [CNT_W-1:0]  cc, pc, rp;
  logic [1:0]        k;
  heap_t             root, tail, a_item;
  logic [STAT_W-1:0] res_status;
  logic [CELL_W-1:0] res_cell;
  logic              res_last;

  // Derived geometry.
  logic [XY_W-1:0]   sx, sy, dx, dy, cur_x, cur_y, nx, ny, hx, hy;
  logic [XY_W:0]     h;
  logic [CELL_W-1:0] start_cell, dest_cell, nb;
  logic              nb_ok;
  logic [G_W-1:0]    ng;
  logic [F_W-1:0]    nf;
  heap_t             it;

  // Path walk.
  logic [CELL_W+1:0] nxt_w;
  logic [CELL_W-1:0] nxt;
  logic              nxt_ok;

  // Memory ports.
  logic              fence_we, fence_wd, fence_q;
  logic [CELL_W-1:0] fence_wa;
  logic              closed_we, closed_wd, closed_q;
  logic [CELL_W-1:0] closed_wa;
  logic              open_we;
  logic [CELL_W-1:0] open_wa;
  logic [POS_W-1:0]  open_wd, open_q;
  logic              par_we;
  logic [CELL_W-1:0] par_wa, par_ra;
  logic [1:0]        par_wd, par_q;
  logic              heap_we;
  logic [POS_W-1:0]  heap_wa, heap_ra;
  heap_t             heap_wd, heap_q;
  logic              path_we;
  logic [CELL_W-1:0] path_wa, path_wd, path_q;

  assign sx = clamp_xy(cfg.start_x);
  assign sy = clamp_xy(cfg.start_y);
  assign dx = clamp_xy(cfg.dest_x);
  assign dy = clamp_xy(cfg.dest_y);
  assign start_cell = CELL_W'(sx) + CELL_W'(sy) * CELL_W'(GRID_SIDE);
  assign dest_cell  = CELL_W'(dx) + CELL_W'(dy) * CELL_W'(GRID_SIDE);
  assign cur_x = XY_W'(cur % GRID_SIDE);
  assign cur_y = XY_W'(cur / GRID_SIDE);

  always_comb begin
    nb_ok = 1'b0;
    nb    = cur;
    nx    = cur_x;
    ny    = cur_y;
    case (k)
      DIR_LEFT: begin
        nb_ok = (cur_x != '0);
        nb    = cur - CELL_W'(1);
        nx    = cur_x - XY_W'(1);
      end
      DIR_UP: begin
        nb_ok = (cur_y != '0);
        nb    = cur - CELL_W'(GRID_SIDE);
        ny    = cur_y - XY_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (cur_x != XY_W'(GRID_SIDE - 1));
        nb    = cur + CELL_W'(1);
        nx    = cur_x + XY_W'(1);
      end
      default: begin
        nb_ok = (cur_y != XY_W'(GRID_SIDE - 1));
        nb    = cur + CELL_W'(GRID_SIDE);
        ny    = cur_y + XY_W'(1);
      end
    endcase
  end

  assign hx = (nx > dx) ? nx - dx : dx - nx;
  assign hy = (ny > dy) ? ny - dy : dy - ny;
  assign h  = {1'b0, hx} + {1'b0, hy};
  assign ng = cur_g + G_W'(cfg.score_step);
  assign nf = F_W'(ng) + F_W'(h);
  assign it = '{node: nb_cell, g: it_g, f: it_f};

  always_comb begin
    case (par_q)
      DIR_LEFT:  nxt_w = {2'b00, walk} - (CELL_W+2)'(1);
      DIR_UP:    nxt_w = {2'b00, walk} - (CELL_W+2)'(GRID_SIDE);
      DIR_RIGHT: nxt_w = {2'b00, walk} + (CELL_W+2)'(1);
      default:   nxt_w = {2'b00, walk} + (CELL_W+2)'(GRID_SIDE);
    endcase
  end
  assign nxt    = nxt_w[CELL_W-1:0];
  assign nxt_ok = (nxt_w < (CELL_W+2)'(CELLS));

  // Status towards the controller.
  always_comb begin
    st.op         = in_q.op;
    st.clr_last   = (clr == CELL_W'(CELLS - 1));
    st.at_dest    = (cur == dest_cell);
    st.nb_ok      = nb_ok;
    st.k_last     = (k == DIR_DOWN);
    st.nb_skip    = fence_q | closed_q;
    st.nb_open    = (open_q != '0);
    st.heap_room  = (hc < POS_W'(HEAP_DEPTH));
    st.worse      = (heap_q.f > it_f);
    st.pos_up     = (pos > POS_W'(1));
    st.su_move    = (it_f < heap_q.f);
    st.heap_empty = (hc == '0);
    st.pop_last   = (hc == POS_W'(1));
    st.c_in       = (c <= {1'b0, hc});
    st.c_sib      = (c < {1'b0, hc});
    st.tail_stop  = (tail.f <= a_item.f);
    st.over_limit = ({1'b0, cc} + (CNT_W+1)'(1)) > {1'b0, cfg.expansion_limit};
    st.cur_start  = (cur == start_cell);
    st.walk_more  = nxt_ok && (nxt != start_cell) && (pc < CNT_W'(CELLS));
    st.rd_avail   = (rp < pc);
    st.out_free   = !out_valid || out_ready;
  end

  // Memory write and read selection.
  always_comb begin
    fence_we  = 1'b0;
    fence_wa  = in_q.cell_req[CELL_W-1:0];
    fence_wd  = in_q.fence;
    closed_we = 1'b0;
    closed_wa = clr;
    closed_wd = 1'b0;
    open_we   = 1'b0;
    open_wa   = clr;
    open_wd   = '0;
    par_we    = 1'b0;
    par_wa    = nb_cell;
    par_wd    = opposite_dir(k);
    par_ra    = nxt;
    heap_we   = 1'b0;
    heap_wa   = pos;
    heap_wd   = it;
    heap_ra   = '0;
    path_we   = 1'b0;
    path_wa   = pc[CELL_W-1:0];
    path_wd   = nxt;
    case (cmd.uop)
      U_RST: begin
        fence_we = 1'b1;
        fence_wa = clr;
        fence_wd = 1'b0;
      end
      U_DEC: begin
        fence_we = (in_q.op == OP_FENCE) && (int'(in_q.cell_req) < CELLS);
      end
      U_CLR: begin
        closed_we = 1'b1;
        open_we   = 1'b1;
      end
      U_INIT: begin
        closed_we = 1'b1;
        closed_wa = start_cell;
        closed_wd = 1'b1;
      end
      U_NBW: begin
        heap_ra = open_q;
        par_we  = !st.nb_skip && !st.nb_open && st.heap_room;
      end
      U_CMP: begin
        par_we = st.worse;
      end
      U_SU: begin
        heap_ra = pos >> 1;
        if (!st.pos_up) begin
          heap_we = 1'b1;
          open_we = 1'b1;
          open_wa = nb_cell;
          open_wd = pos;
        end
      end
      U_SUW: begin
        heap_we = 1'b1;
        open_we = 1'b1;
        open_wd = pos;
        if (st.su_move) begin
          heap_wd = heap_q;
          open_wa = heap_q.node;
        end else begin
          open_wa = nb_cell;
        end
      end
      U_AFTER: heap_ra = POS_W'(1);
      U_POP1:  heap_ra = hc;
      U_POP2: begin
        open_we = 1'b1;
        open_wa = root.node;
        open_wd = '0;
      end
      U_PD: begin
        heap_ra = c[POS_W-1:0];
        if (!st.c_in) begin
          heap_we = 1'b1;
          heap_wa = p;
          heap_wd = tail;
          open_we = 1'b1;
          open_wa = tail.node;
          open_wd = p;
        end
      end
      U_PD1: heap_ra = POS_W'(c + 1'b1);
      U_PD3: begin
        heap_we = 1'b1;
        heap_wa = p;
        open_we = 1'b1;
        open_wd = p;
        if (st.tail_stop) begin
          heap_wd = tail;
          open_wa = tail.node;
        end else begin
          heap_wd = a_item;
          open_wa = a_item.node;
        end
      end
      U_CLOSE: begin
        closed_we = 1'b1;
        closed_wa = root.node;
        closed_wd = 1'b1;
      end
      U_PATH0: begin
        path_we = 1'b1;
        path_wa = '0;
        path_wd = cur;
        par_ra  = cur;
      end
      U_PATH1: begin
        path_we = st.walk_more;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      hc        <= '0;
      cc        <= '0;
      pc        <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.uop == U_RST || cmd.uop == U_CLR) begin
        clr <= st.clr_last ? '0 : clr + CELL_W'(1);
      end
      case (cmd.uop)
        U_INIT: begin
          hc <= '0;
          cc <= CNT_W'(1);
        end
        U_NBW:   if (!st.nb_skip && !st.nb_open && st.heap_room) hc <= hc + POS_W'(1);
        U_POP2:  hc <= hc - POS_W'(1);
        U_CLOSE: cc <= cc + CNT_W'(1);
        U_AFTER: begin
          if (st.heap_empty) begin
            pc <= '0;
            rp <= '0;
          end
        end
        U_PATH0: begin
          pc <= CNT_W'(1);
          rp <= '0;
        end
        U_PATH1: if (st.walk_more) pc <= pc + CNT_W'(1);
        U_RD:    rp <= rp + CNT_W'(1);
        default: ;
      endcase
      if (cmd.uop == U_FIN && st.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the search.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_q <= in_data;
    end
    case (cmd.uop)
      U_DEC: begin
        res_status <= (in_q.op == OP_READ && !st.rd_avail) ? ST_NOPATH : ST_DONE;
        res_cell   <= '0;
        res_last   <= 1'b0;
      end
      U_RD: begin
        res_cell <= path_q;
        res_last <= ((rp + CNT_W'(1)) == pc);
      end
      U_INIT: begin
        cur   <= start_cell;
        cur_g <= '0;
      end
      U_CHECK: k <= DIR_LEFT;
      U_NB: begin
        nb_cell <= nb;
        it_g    <= ng;
        it_f    <= nf;
      end
      U_NBW: begin
        if (st.nb_open) pos <= open_q;
        else pos <= hc + POS_W'(1);
      end
      U_SUW:   if (st.su_move) pos <= pos >> 1;
      U_NEXT:  k <= k + 2'd1;
      U_AFTER: if (st.heap_empty) res_status <= ST_NOPATH;
      U_POP1:  root <= heap_q;
      U_POP2: begin
        tail <= heap_q;
        p    <= POS_W'(1);
        c    <= (POS_W+1)'(2);
      end
      U_PD1: a_item <= heap_q;
      U_PD2: begin
        if (a_item.f > heap_q.f) begin
          a_item <= heap_q;
          c      <= c + (POS_W+1)'(1);
        end
      end
      U_PD3: begin
        if (!st.tail_stop) begin
          p <= c[POS_W-1:0];
          c <= c << 1;
        end
      end
      U_CLOSE: begin
        cur   <= root.node;
        cur_g <= root.g;
      end
      U_PATH0: begin
        walk       <= cur;
        res_status <= st.at_dest ? ST_REACHED : ST_LIMIT;
      end
      U_PATH1: if (st.walk_more) walk <= nxt;
      default: ;
    endcase
    if (cmd.uop == U_FIN && st.out_free) begin
      out_data.status      <= res_status;
      out_data.path_length <= pc;
      out_data.path_cell   <= PCELL_W'(res_cell);
      out_data.last        <= res_last;
    end
  end

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_fence (
    .clk(clk), .we(fence_we), .waddr(fence_wa), .wdata(fence_wd),
    .raddr(nb), .rdata(fence_q)
  );

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_closed (
    .clk(clk), .we(closed_we), .waddr(closed_wa), .wdata(closed_wd),
    .raddr(nb), .rdata(closed_q)
  );

  gaps_ram #(.WIDTH(POS_W), .DEPTH(CELLS)) u_open (
    .clk(clk), .we(open_we), .waddr(open_wa), .wdata(open_wd),
    .raddr(nb), .rdata(open_q)
  );

  gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
    .raddr(par_ra), .rdata(par_q)
  );

  gaps_ram #(.WIDTH($bits(heap_t)), .DEPTH(HEAP_DEPTH + 1)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
    .raddr(heap_ra), .rdata(heap_q)
  );

  gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
    .clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
    .raddr(rp[CELL_W-1:0]), .rdata(path_q)
  );

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    hc <= POS_W'(HEAP_DEPTH))
    else $error("heap count beyond heap depth");

  a_read_ptr: assert property (@(posedge clk) disable iff (rst)
    rp <= pc)
    else $error("path read pointer beyond stored path");

  a_closed_step: assert property (@(posedge clk) disable iff (rst)
    cc != $past(cc) |-> (cc == $past(cc) + CNT_W'(1)) || (cc == CNT_W'(1)))
    else $error("closed count moved by more than one");

endmodule

// ===== rtl/grid_astar_path_search_core.sv =====
`timescale 1ns / 1ps
// Fence write and unused op: the item is decoded, then its result is loaded into the output register;
// a path read passes a path-store read state between the two. With the output free, the block
// returns to idle as soon as a result is loaded. Search: a clear of the closed and open-position
// maps, then per expanded cell the neighbour checks and heap walks, then one path cell per cycle.
// One item is in flight at a time; a finished result waits in the output register.
// Synchronous reset; afterwards the fence map is swept clear before any item is taken.
module grid_astar_path_search_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gaps_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gaps_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gaps_pkg::ADDR_W-1:0]   paddr,
  input  logic [gaps_pkg::DATA_W-1:0]   pwdata,
  output logic [gaps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import gaps_pkg::*;

  // Configuration registers, one per 32-bit word. The search reads them
  // live, so they must only be written while the block is idle.
  cfg_t cfg;
  cmd_t cmd;
  st_t  st;
  logic [2:0] reg_idx;
  logic       wr_beat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_beat = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x         <= '0;
      cfg.start_y         <= '0;
      cfg.dest_x          <= '0;
      cfg.dest_y          <= '0;
      cfg.score_step      <= STEP_W'(10);
      cfg.expansion_limit <= LIMIT_W'(2047);
    end else if (wr_beat) begin
      case (reg_idx)
        REG_START_X: cfg.start_x         <= pwdata[CFG_XY_W-1:0];
        REG_START_Y: cfg.start_y         <= pwdata[CFG_XY_W-1:0];
        REG_DEST_X:  cfg.dest_x          <= pwdata[CFG_XY_W-1:0];
        REG_DEST_Y:  cfg.dest_y          <= pwdata[CFG_XY_W-1:0];
        REG_STEP:    cfg.score_step      <= pwdata[STEP_W-1:0];
        REG_LIMIT:   cfg.expansion_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register file; unmapped words read as zero.
  always_comb begin
    case (reg_idx)
      REG_START_X: prdata = DATA_W'(cfg.start_x);
      REG_START_Y: prdata = DATA_W'(cfg.start_y);
      REG_DEST_X:  prdata = DATA_W'(cfg.dest_x);
      REG_DEST_Y:  prdata = DATA_W'(cfg.dest_y);
      REG_STEP:    prdata = DATA_W'(cfg.score_step);
      REG_LIMIT:   prdata = DATA_W'(cfg.expansion_limit);
      default:     prdata = '0;
    endcase
  end

  // The controller sequences each operation; the datapath holds the grid
  // maps, the heap, the path store and the output register.
  assign in_ready = cmd.in_ready;

  gaps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .st(st), .cmd(cmd)
  );

  gaps_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .in_data(in_data),
    .out_ready(out_ready), .st(st), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
